// File: hw/rtl/conv3x3_clamped_border_macros.svh
// Assertion macros used by the checker of the 3x3 convolution block.
`ifndef CONV3X3_CLAMPED_BORDER_MACROS_SVH
`define CONV3X3_CLAMPED_BORDER_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define C3CB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("c3cb assertion failed");

// Next-cycle implication, disabled while reset is active.
`define C3CB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("c3cb assertion failed");

// Same-cycle implication that is also checked during reset.
`define C3CB_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("c3cb assertion failed");

`endif

// File: hw/rtl/c3cb_pkg.sv
// Types and constants shared by the 3x3 convolution block.
package c3cb_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int PIXEL_W      = 48;
  localparam int RESULT_W     = 37;
  localparam int ROW_W        = 11;
  localparam int CFG_W        = 48;
  localparam int CFG_IDX_W    = 3;
  localparam int MAX_CHANNELS = 3;
  localparam int KERNEL_SIZE  = 3;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int OQ_DEPTH     = 8;
  localparam int OQ_PTR_W     = 3;
  localparam int OUT_TDATA_W  = 112;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_CHANNELS = 3'd2,
    REG_KEEP     = 3'd3,
    REG_KTOP     = 3'd4,
    REG_KMID     = 3'd5,
    REG_KBOT     = 3'd6
  } reg_idx_e;

  // Kind of an input word.
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef logic [PIXEL_W-1:0] pixel_t;

  // One window column, index 0 is the top row.
  typedef logic [KERNEL_SIZE-1:0][PIXEL_W-1:0] column_t;

  typedef struct packed {
    op_e    op;
    pixel_t pixel;
  } item_t;

  // Neighborhood of one result, cols[0] is the left column.
  typedef struct packed {
    column_t [KERNEL_SIZE-1:0] cols;
    logic                      frame_end;
  } emit_t;

  // Settings used by the arithmetic pipeline.
  typedef struct packed {
    logic [KERNEL_SIZE-1:0][CFG_W-1:0] kernel;
    logic [1:0]                        channels;
    logic                              keep;
  } mac_cfg_t;

  typedef struct packed {
    logic                       frame_end;
    logic signed [RESULT_W-1:0] result_c;
    logic signed [RESULT_W-1:0] result_b;
    logic signed [RESULT_W-1:0] result_a;
  } result_t;

endpackage

// File: hw/rtl/c3cb_front.sv
// Input queue that takes words from the stream and decodes their kind.
module c3cb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic               s_kind_i,
  input  c3cb_pkg::pixel_t   s_pixel_i,
  input  logic               pop_i,
  output logic               head_valid_o,
  output c3cb_pkg::item_t    head_o
);

  c3cb_pkg::item_t entries_q [2];
  c3cb_pkg::item_t in_item;
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;

  // Decode the incoming word.
  always_comb begin
    in_item.op    = c3cb_pkg::op_e'(s_kind_i);
    in_item.pixel = s_pixel_i;
  end

  assign s_ready_o    = (cnt_q != 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = entries_q[rd_q];
  assign push         = s_valid_i && s_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_q] <= in_item;
    end
  end

endmodule

// File: hw/rtl/c3cb_line_store.sv
// One line buffer with a registered read port and write-through on a same-address hit.
module c3cb_line_store #(
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  c3cb_pkg::pixel_t wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output c3cb_pkg::pixel_t rdata_o
);

  c3cb_pkg::pixel_t mem_q [DEPTH];
  c3cb_pkg::pixel_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/c3cb_engine.sv
// Window engine: walks the raster position, keeps the line buffers and window, picks results.
module c3cb_engine #(
  parameter  int MAX_WIDTH = 1024,
  localparam int XW        = $clog2(MAX_WIDTH),
  localparam int WW        = $clog2(MAX_WIDTH + 1),
  localparam int PW        = WW + c3cb_pkg::ROW_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  c3cb_pkg::item_t            head_i,
  output logic                       pop_o,
  input  logic                       room_i,
  input  logic                       restart_i,
  input  logic [WW-1:0]              width_i,
  input  logic [c3cb_pkg::ROW_W-1:0] height_i,
  input  logic [PW-1:0]              total_i,
  output logic                       emit_valid_o,
  output c3cb_pkg::emit_t            emit_o
);

  localparam int RW = c3cb_pkg::ROW_W;

  logic [XW-1:0] ix_q, ix_d;
  logic [RW-1:0] iy_q, iy_d, iy_next;
  logic [PW-1:0] outpos_q, outpos_d;
  logic          flushing_q, flushing_d;
  logic          second_q, second_d;
  c3cb_pkg::column_t [2:0] win_q, win_d;

  logic [WW-1:0]     ix_inc;
  logic              is_pixel, go, drain_live, restart_cyc, step;
  logic              wrap, e1, e2, upd, emitted;
  c3cb_pkg::pixel_t  upper_rd, lower_rd, top, mid, bot;
  c3cb_pkg::column_t new_col;
  logic              store_we;

  // Step decision and the values of one column step.
  always_comb begin
    is_pixel    = (head_i.op == c3cb_pkg::OP_PIXEL);
    go          = head_valid_i && room_i && !restart_i;
    drain_live  = flushing_q && (outpos_q < total_i);
    restart_cyc = go && is_pixel && flushing_q;
    step        = go && !restart_cyc && (is_pixel || drain_live);

    ix_inc  = WW'(ix_q) + WW'(1);
    wrap    = (ix_inc >= width_i);
    iy_next = wrap ? (iy_q + RW'(1)) : iy_q;

    e1      = (ix_q == '0) && (iy_q >= RW'(2));
    upd     = is_pixel || (iy_q <= height_i);
    e2      = !e1 && upd && (ix_q != '0) && (iy_q != '0);
    emitted = e1 || e2;

    mid = lower_rd;
    top = (iy_q == RW'(1)) ? lower_rd : upper_rd;
    bot = is_pixel ? head_i.pixel : lower_rd;
    new_col[0] = top;
    new_col[1] = mid;
    new_col[2] = bot;
  end

  // Neighborhood of the result; the start of a row replicates the left edge and the end of a row the right edge.
  always_comb begin
    if (e1) begin
      emit_o.cols[0] = (width_i >= WW'(2)) ? win_q[1] : win_q[2];
      emit_o.cols[1] = win_q[2];
      emit_o.cols[2] = win_q[2];
    end else begin
      emit_o.cols[0] = (ix_q == XW'(1)) ? win_q[2] : win_q[1];
      emit_o.cols[1] = win_q[2];
      emit_o.cols[2] = new_col;
    end
    emit_o.frame_end = ((outpos_q + PW'(1)) == total_i);
  end

  assign emit_valid_o = step && emitted;
  assign store_we     = step && is_pixel;

  // A drain that yields nothing on its first column gets a second one.
  always_comb begin
    pop_o = 1'b0;
    if (go && !restart_cyc) begin
      pop_o = is_pixel || !drain_live || emitted || second_q;
    end
  end

  // Next state.
  always_comb begin
    ix_d       = ix_q;
    iy_d       = iy_q;
    outpos_d   = outpos_q;
    flushing_d = flushing_q;
    second_d   = second_q;
    win_d      = win_q;
    if (restart_i || restart_cyc) begin
      ix_d       = '0;
      iy_d       = '0;
      outpos_d   = '0;
      flushing_d = 1'b0;
      second_d   = 1'b0;
    end else if (step) begin
      ix_d = wrap ? '0 : XW'(ix_inc);
      iy_d = iy_next;
      if (emitted) begin
        outpos_d = outpos_q + PW'(1);
      end
      if (is_pixel && (iy_next >= height_i)) begin
        flushing_d = 1'b1;
      end
      if (upd) begin
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = new_col;
      end
      second_d = pop_o ? 1'b0 : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ix_q       <= '0;
      iy_q       <= '0;
      outpos_q   <= '0;
      flushing_q <= 1'b0;
      second_q   <= 1'b0;
      win_q      <= '0;
    end else begin
      ix_q       <= ix_d;
      iy_q       <= iy_d;
      outpos_q   <= outpos_d;
      flushing_q <= flushing_d;
      second_q   <= second_d;
      win_q      <= win_d;
    end
  end

  // Line buffers; the read address follows the next column so data is ready in time.
  c3cb_line_store #(.DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (ix_q),
    .wdata_i (lower_rd),
    .raddr_i (ix_d),
    .rdata_o (upper_rd)
  );

  c3cb_line_store #(.DEPTH(MAX_WIDTH)) u_lower (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (ix_q),
    .wdata_i (head_i.pixel),
    .raddr_i (ix_d),
    .rdata_o (lower_rd)
  );

endmodule

// File: hw/rtl/c3cb_mac.sv
// Multiply-accumulate pipeline and output queue.
module c3cb_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  c3cb_pkg::mac_cfg_t  cfg_i,
  input  logic                emit_valid_i,
  input  c3cb_pkg::emit_t     emit_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output c3cb_pkg::result_t   out_word_o
);

  localparam int RW = c3cb_pkg::RESULT_W;
  localparam int QW = c3cb_pkg::OQ_PTR_W;

  c3cb_pkg::emit_t e0_q;
  logic            v0_q, v1_q, v2_q, v3_q;
  logic            fe1_q, fe2_q, fe3_q;

  logic signed [33:0]   prod_d [3][3][3];
  logic signed [33:0]   prod_q [3][3][3];
  logic signed [RW-1:0] rsum_d [3][3];
  logic signed [RW-1:0] rsum_q [3][3];
  logic signed [RW-1:0] csum_d [3];
  logic signed [RW-1:0] csum_q [3];
  logic signed [16:0]   coef   [3][3][3];
  logic signed [16:0]   samp   [3][3][3];
  logic [1:0]           chan_n;

  c3cb_pkg::result_t oq_q [c3cb_pkg::OQ_DEPTH];
  c3cb_pkg::result_t word;
  logic [QW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QW:0]       occ_q, inflight_q;
  logic              pop;

  assign chan_n = (cfg_i.channels == 2'd0) ? 2'd1 : cfg_i.channels;

  // Products; channels beyond the configured count contribute nothing.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          coef[ch][r][c] = {cfg_i.kernel[r][16*c+15], cfg_i.kernel[r][16*c +: 16]};
          samp[ch][r][c] = (2'(ch) < chan_n) ? {1'b0, e0_q.cols[c][r][16*ch +: 16]} : '0;
          prod_d[ch][r][c] = coef[ch][r][c] * samp[ch][r][c];
        end
      end
    end
  end

  // Row sums, then channel sums.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        rsum_d[ch][r] = RW'(prod_q[ch][r][0]) + RW'(prod_q[ch][r][1])
                      + RW'(prod_q[ch][r][2]);
      end
      csum_d[ch] = rsum_q[ch][0] + rsum_q[ch][1] + rsum_q[ch][2];
    end
  end

  // Final word: separate channels or their sum.
  always_comb begin
    word.frame_end = fe3_q;
    if (cfg_i.keep) begin
      word.result_a = csum_q[0];
      word.result_b = csum_q[1];
      word.result_c = csum_q[2];
    end else begin
      word.result_a = csum_q[0] + csum_q[1] + csum_q[2];
      word.result_b = '0;
      word.result_c = '0;
    end
  end

  // Pipeline data.
  always_ff @(posedge clk_i) begin
    e0_q   <= emit_i;
    prod_q <= prod_d;
    fe1_q  <= e0_q.frame_end;
    rsum_q <= rsum_d;
    fe2_q  <= fe1_q;
    csum_q <= csum_d;
    fe3_q  <= fe2_q;
    if (v3_q) begin
      oq_q[wr_ptr_q] <= word;
    end
  end

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (occ_q != '0);
  assign out_word_o  = oq_q[rd_ptr_q];
  assign room_o      = (inflight_q < (QW+1)'(c3cb_pkg::OQ_DEPTH));

  // Valids, queue pointers and the count of results not yet taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q       <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      occ_q      <= '0;
      inflight_q <= '0;
    end else begin
      v0_q <= emit_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (v3_q) begin
        wr_ptr_q <= wr_ptr_q + QW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QW'(1);
      end
      occ_q      <= occ_q + (QW+1)'(v3_q) - (QW+1)'(pop);
      inflight_q <= inflight_q + (QW+1)'(emit_valid_i) - (QW+1)'(pop);
    end
  end

endmodule

// File: hw/rtl/conv3x3_clamped_border.sv
// Streaming 3x3 convolution with replicated image borders.
//
// Input words arrive on the s_axis channel: tuser 0 carries a pixel with
// three 16-bit unsigned samples, tuser 1 is a drain word that flushes one
// pending result after the last pixel of a frame. Results leave on m_axis,
// three 37-bit signed sums with 8 fraction bits; tlast marks the result of
// the last pixel of the frame. Results lag their pixels by one row plus one
// column, so a frame of W x H pixels needs drain words after its last pixel.
// Throughput is one word per cycle while the output queue has room; a drain
// word may walk two columns, and the first pixel of a new frame after a
// flush waits while the raster position and the line buffer read rewind.
// Results pass the emit, product, row-sum and channel-sum registers. An
// eight-entry output queue absorbs a stalled receiver; when
// it is full the engine holds and the two-entry input queue fills, then
// s_axis_tready drops. Reset empties both queues, clears the window and the
// raster position and loads the default registers; the line buffers are not
// cleared. Writing the width or height restarts the frame.
module conv3x3_clamped_border #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_a, sample_b, sample_c
  input  logic [c3cb_pkg::PIXEL_W-1:0]         s_axis_tdata,
  // operation
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // result_a, result_b, result_c, one pad bit
  output logic [c3cb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // frame_end
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_we_i,
  input  logic [c3cb_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [c3cb_pkg::CFG_W-1:0]           cfg_data_i
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = c3cb_pkg::ROW_W;
  localparam int PW = WW + RW;

  logic [10:0]       width_q, height_q;
  logic [1:0]        chan_q;
  logic              keep_q;
  logic [2:0][47:0]  kernel_q;
  logic [WW-1:0]     w_eff;
  logic [RW-1:0]     h_eff;
  logic [PW-1:0]     total_q;
  logic              restart;

  c3cb_pkg::item_t    head;
  logic               head_valid, pop, room, emit_valid;
  c3cb_pkg::emit_t    emit;
  c3cb_pkg::mac_cfg_t mac_cfg;
  c3cb_pkg::result_t  out_word;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 11'd1024;
      chan_q   <= 2'd1;
      keep_q   <= 1'b1;
      kernel_q <= {48'd0, 48'd256, 48'd0};
    end else if (cfg_we_i) begin
      case (c3cb_pkg::reg_idx_e'(cfg_idx_i))
        c3cb_pkg::REG_WIDTH:    width_q     <= cfg_data_i[10:0];
        c3cb_pkg::REG_HEIGHT:   height_q    <= cfg_data_i[10:0];
        c3cb_pkg::REG_CHANNELS: chan_q      <= cfg_data_i[1:0];
        c3cb_pkg::REG_KEEP:     keep_q      <= cfg_data_i[0];
        c3cb_pkg::REG_KTOP:     kernel_q[0] <= cfg_data_i;
        c3cb_pkg::REG_KMID:     kernel_q[1] <= cfg_data_i;
        c3cb_pkg::REG_KBOT:     kernel_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i &&
                   ((c3cb_pkg::reg_idx_e'(cfg_idx_i) == c3cb_pkg::REG_WIDTH) ||
                    (c3cb_pkg::reg_idx_e'(cfg_idx_i) == c3cb_pkg::REG_HEIGHT));

  // Clamped frame size.
  always_comb begin
    if (width_q == 11'd0) begin
      w_eff = WW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == 11'd0) begin
      h_eff = RW'(1);
    end else if (int'(height_q) > c3cb_pkg::HEIGHT_LIMIT) begin
      h_eff = RW'(c3cb_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = height_q;
    end
  end

  // Pixel count of a frame.
  always_ff @(posedge clk_i) begin
    total_q <= PW'(w_eff) * PW'(h_eff);
  end

  always_comb begin
    mac_cfg.kernel   = kernel_q;
    mac_cfg.channels = chan_q;
    mac_cfg.keep     = keep_q;
  end

  c3cb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_kind_i     (s_axis_tuser),
    .s_pixel_i    (s_axis_tdata),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  c3cb_engine #(.MAX_WIDTH(MAX_WIDTH)) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .room_i       (room),
    .restart_i    (restart),
    .width_i      (w_eff),
    .height_i     (h_eff),
    .total_i      (total_q),
    .emit_valid_o (emit_valid),
    .emit_o       (emit)
  );

  c3cb_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (mac_cfg),
    .emit_valid_i (emit_valid),
    .emit_i       (emit),
    .room_o       (room),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_word_o   (out_word)
  );

  assign m_axis_tdata = {1'b0, out_word.result_c, out_word.result_b, out_word.result_a};
  assign m_axis_tlast = out_word.frame_end;

endmodule

// File: hw/rtl/c3cb_checker.sv
// Port-level checks for the 3x3 convolution block, bound to its top level.
`include "conv3x3_clamped_border_macros.svh"

module c3cb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [c3cb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);

  // A result offered and not taken stays offered.
  `C3CB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // A stalled result keeps its value.
  `C3CB_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // The pad bit above the three results is always zero.
  `C3CB_ASSERT_IMP(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[c3cb_pkg::OUT_TDATA_W-1] == 1'b0)

  // Reset empties the output queue.
  `C3CB_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni, !m_axis_tvalid)

endmodule

bind conv3x3_clamped_border c3cb_checker u_checker (.*);
